FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/tbes_pkg.sv
// ----------------------------------------------------------------------------
// tbes_pkg
// constants and types shared by the two-body excitation sign block
// ----------------------------------------------------------------------------
package tbes_pkg;

  // orbital space
  localparam int ORBITALS = 16;
  localparam int OCC_W    = 16;
  localparam int ORB_LIMIT = (ORBITALS < OCC_W) ? ORBITALS : OCC_W;
  localparam logic [OCC_W-1:0] ORB_MASK =
    (ORB_LIMIT >= OCC_W) ? '1 : OCC_W'((1 << ORB_LIMIT) - 1);

  // index widths: spatial index plus one spin bit
  localparam int IDX_W    = 4;
  localparam int SO_IDX_W = IDX_W + 1;

  // spin combinations summed in spin mode
  localparam int TERMS = 4;

  // result
  localparam int VAL_W = 4;
  localparam logic signed [VAL_W-1:0] VAL_ONE       = VAL_W'(1);
  localparam logic signed [VAL_W-1:0] VAL_MINUS_ONE = VAL_W'(-1);
  localparam logic signed [VAL_W-1:0] VAL_MIN       = VAL_W'(-4);
  localparam logic signed [VAL_W-1:0] VAL_MAX       = VAL_W'(4);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_MODE = CFG_IDX_W'(0);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // spin-orbital indices of one quartet
  typedef struct packed {
    logic [SO_IDX_W-1:0] p;
    logic [SO_IDX_W-1:0] r;
    logic [SO_IDX_W-1:0] s;
    logic [SO_IDX_W-1:0] q;
  } quartet_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [OCC_W-1:0]            bra;
    logic [OCC_W-1:0]            ket;
    logic [TERMS-1:0]            term_en;
    quartet_t [TERMS-1:0]        terms;
  } job_t;

endpackage

FILE: rtl/tbes_if.sv
// ----------------------------------------------------------------------------
// tbes_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface tbes_in_if;
  import tbes_pkg::*;

  logic             valid;
  logic             ready;
  logic [OCC_W-1:0] bra_occupancy;
  logic [OCC_W-1:0] ket_occupancy;
  logic [IDX_W-1:0] create_first;
  logic [IDX_W-1:0] create_second;
  logic [IDX_W-1:0] annihilate_first;
  logic [IDX_W-1:0] annihilate_second;

  modport source (
    output valid, bra_occupancy, ket_occupancy, create_first, create_second,
           annihilate_first, annihilate_second,
    input  ready
  );
  modport sink (
    input  valid, bra_occupancy, ket_occupancy, create_first, create_second,
           annihilate_first, annihilate_second,
    output ready
  );
endinterface

interface tbes_out_if;
  import tbes_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] element_value;

  modport source (output valid, element_value, input ready);
  modport sink   (input valid, element_value, output ready);
endinterface

FILE: rtl/tbes_front.sv
// ----------------------------------------------------------------------------
// tbes_front
// accepts items and expands them into spin-orbital quartets
// ----------------------------------------------------------------------------
module tbes_front (
  tbes_in_if.sink          in_item,
  input  logic             spin_mode,
  output logic             push_valid,
  input  logic             push_ready,
  output tbes_pkg::job_t   push_data
);
  import tbes_pkg::*;

  logic sg;
  logic tu;

  // handshake passes straight to the queue
  assign push_valid = in_item.valid;
  assign in_item.ready = push_ready;

  // masks limited to the orbital space, quartets per spin pairing
  always_comb begin
    push_data.bra = in_item.bra_occupancy & ORB_MASK;
    push_data.ket = in_item.ket_occupancy & ORB_MASK;
    for (int k = 0; k < TERMS; k++) begin
      sg = 1'(k >> 1);
      tu = 1'(k);
      if (spin_mode) begin
        push_data.term_en[k]  = 1'b1;
        push_data.terms[k].p = {in_item.create_first, sg};
        push_data.terms[k].r = {in_item.create_second, tu};
        push_data.terms[k].s = {in_item.annihilate_first, tu};
        push_data.terms[k].q = {in_item.annihilate_second, sg};
      end else begin
        push_data.term_en[k]  = (k == 0);
        push_data.terms[k].p = {1'b0, in_item.create_first};
        push_data.terms[k].r = {1'b0, in_item.create_second};
        push_data.terms[k].s = {1'b0, in_item.annihilate_first};
        push_data.terms[k].q = {1'b0, in_item.annihilate_second};
      end
    end
  end

endmodule

FILE: rtl/tbes_queue.sv
// ----------------------------------------------------------------------------
// tbes_queue
// short flip-flop queue decoupling front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbes_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tbes_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tbes_pkg::job_t pop_data
);
  import tbes_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  // transfer qualifiers
  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_NEXT(a_push_lands, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "push lost")
  `ASSERT_NEXT(a_pop_leaves, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1, "pop lost")

endmodule

FILE: rtl/tbes_back.sv
// ----------------------------------------------------------------------------
// tbes_back
// strips orbitals, checks parities and sums the quartet signs
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbes_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  tbes_pkg::job_t  pop_data,
  tbes_out_if.source      out_res
);
  import tbes_pkg::*;

  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [OCC_W-1:0] rest;
  } strip_t;

  // one-hot of a spin orbital, empty outside the orbital space
  function automatic logic [OCC_W-1:0] orbital_bit(logic [SO_IDX_W-1:0] idx);
    logic [OCC_W-1:0] oh;
    oh = '0;
    if (idx < SO_IDX_W'(ORB_LIMIT)) begin
      oh = OCC_W'(1) << idx;
    end
    return oh;
  endfunction

  // remove a then b, each needing occupancy, sign from parity below
  function automatic strip_t strip_pair(logic [OCC_W-1:0] m,
                                        logic [OCC_W-1:0] a_oh,
                                        logic [OCC_W-1:0] b_oh);
    strip_t           res;
    logic [OCC_W-1:0] m1;
    m1       = m & ~a_oh;
    res.ok   = (|(m & a_oh)) && (|(m1 & b_oh));
    res.neg  = (^(m & (a_oh - 1'b1))) ^ (^(m1 & (b_oh - 1'b1)));
    res.rest = m1 & ~b_oh;
    return res;
  endfunction

  logic                    out_val_r;
  logic signed [VAL_W-1:0] out_data_r;
  logic signed [VAL_W-1:0] sum;
  logic                    pop;
  strip_t                  sb [TERMS];
  strip_t                  sk [TERMS];

  assign pop_ready = !out_val_r || out_res.ready;
  assign pop       = pop_valid && pop_ready;

  // per-quartet sign and sum over the enabled spin pairings
  always_comb begin
    sum = '0;
    for (int k = 0; k < TERMS; k++) begin
      sb[k] = strip_pair(pop_data.bra, orbital_bit(pop_data.terms[k].p),
                         orbital_bit(pop_data.terms[k].r));
      sk[k] = strip_pair(pop_data.ket, orbital_bit(pop_data.terms[k].q),
                         orbital_bit(pop_data.terms[k].s));
      if (pop_data.term_en[k] && sb[k].ok && sk[k].ok && (sb[k].rest == sk[k].rest)) begin
        sum = sum + ((sb[k].neg ^ sk[k].neg) ? VAL_MINUS_ONE : VAL_ONE);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_val_r <= 1'b0;
    end else if (pop_ready) begin
      out_val_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= sum;
    end
  end

  assign out_res.valid         = out_val_r;
  assign out_res.element_value = out_data_r;

  `ASSERT_NEXT(a_single_term_range, clk, rst_n, pop && (pop_data.term_en == TERMS'(1)), out_data_r == VAL_ONE || out_data_r == VAL_MINUS_ONE || out_data_r == '0, "spinless result out of range")
  `ASSERT_ALWAYS(a_value_range, clk, rst_n, !out_val_r || (out_data_r >= VAL_MIN && out_data_r <= VAL_MAX), "result out of range")
  `ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, out_val_r, "popped item not presented")

endmodule

FILE: rtl/two_body_excitation_sign.sv
// ----------------------------------------------------------------------------
// two_body_excitation_sign
// two-body excitation matrix element sign between two occupation masks
// ----------------------------------------------------------------------------
// channel   dir  port       transfer carries
// items     in   in_item    bra/ket occupancy, four orbital indices
// results   out  out_res    element_value, signed -4..4
// config    in   cfg_*      apb, spin_mode at byte address 0
//
// one item per cycle sustained while out_res is ready; on its way from input
// transfer to result an item passes the queue register and then the output register
// a two-entry queue lets the front keep accepting while the output stalls
// rst_n is synchronous; spin_mode resets to 0, the queue and output empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_body_excitation_sign (
  input  logic                            clk,
  input  logic                            rst_n,
  tbes_in_if.sink                         in_item,
  tbes_out_if.source                      out_res,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tbes_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [tbes_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [tbes_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import tbes_pkg::*;

  logic                 spin_mode_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;
  logic                 push_valid;
  logic                 push_ready;
  job_t                 push_data;
  logic                 pop_valid;
  logic                 pop_ready;
  job_t                 pop_data;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_mode_r <= 1'b0;
    end else if (cfg_wr && (cfg_idx == REG_SPIN_MODE)) begin
      spin_mode_r <= cfg_pwdata[0];
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_SPIN_MODE: cfg_prdata = CFG_DATA_W'(spin_mode_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // front: accept and classify
  tbes_front u_front (
    .in_item    (in_item),
    .spin_mode  (spin_mode_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue between the two halves
  tbes_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: evaluate and present
  tbes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_res   (out_res)
  );

  `ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_wr && (cfg_idx == REG_SPIN_MODE), spin_mode_r == $past(cfg_pwdata[0]), "spin_mode write lost")
  `ASSERT_NEXT(a_cfg_hold, clk, rst_n, !cfg_wr, spin_mode_r == $past(spin_mode_r), "spin_mode changed without write")
  `ASSERT_ALWAYS(a_front_mode, clk, rst_n, spin_mode_r || (push_data.term_en == TERMS'(1)), "spinless item with spin terms")

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the two-body excitation sign block
// ----------------------------------------------------------------------------
// items go in over the item channel and are scored against an in-bench
// predictor of the matrix element, spinless and spin-summed, one expected
// value per transfer. results are checked in order as they leave the block.
// spin_mode is set over the apb port between phases while the block is idle.
// directed cases cover the extreme masks and indices, repeated indices and
// unoccupied orbitals; random phases mix valid excitations with noise under
// several idling patterns and two long output hold-offs.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tbes_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REG_UNUSED   = 1;

  typedef struct {
    logic [OCC_W-1:0] bra;
    logic [OCC_W-1:0] ket;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] q;
  } excitation_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tbes_in_if  in_if ();
  tbes_out_if out_if ();

  // predictor copy of the configuration and the expected results in order
  logic                    spin_mode_model;
  logic signed [VAL_W-1:0] expected_elements[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          hold_request;
  int          hold_left;
  int          failures;
  int          cycle_count;

  two_body_excitation_sign i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_if),
    .out_res     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL two_body_excitation_sign");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // takes two orbitals out of a mask in turn, sign from occupied ones below
  function automatic int strip_orbital_pair(inout bit [31:0] occ, input int first,
                                            input int second);
    int sign;
    sign = 1;
    if (!occ[first]) return 0;
    if (^(occ & ((32'd1 << first) - 32'd1))) sign = -sign;
    occ[first] = 1'b0;
    if (!occ[second]) return 0;
    if (^(occ & ((32'd1 << second) - 32'd1))) sign = -sign;
    occ[second] = 1'b0;
    return sign;
  endfunction

  // one operator string between two spin-orbital masks
  function automatic int quartet_element(bit [31:0] bra, bit [31:0] ket, int p, int r,
                                         int s, int q);
    int bra_sign;
    int ket_sign;
    bra_sign = strip_orbital_pair(bra, p, r);
    if (bra_sign == 0) return 0;
    ket_sign = strip_orbital_pair(ket, q, s);
    if (ket_sign == 0) return 0;
    return (bra == ket) ? bra_sign * ket_sign : 0;
  endfunction

  function automatic logic signed [VAL_W-1:0] predict_element(excitation_t it);
    bit [31:0] bra;
    bit [31:0] ket;
    int        total;
    bra   = 32'(it.bra & ORB_MASK);
    ket   = 32'(it.ket & ORB_MASK);
    total = 0;
    if (!spin_mode_model) begin
      total = quartet_element(bra, ket, it.p, it.r, it.s, it.q);
    end else begin
      // sigma on p/q, tau on r/s
      for (int sg = 0; sg < 2; sg++) begin
        for (int tu = 0; tu < 2; tu++) begin
          total += quartet_element(bra, ket, 2 * it.p + sg, 2 * it.r + tu,
                                   2 * it.s + tu, 2 * it.q + sg);
        end
      end
    end
    return VAL_W'(total);
  endfunction

  // ------------------------------------------------------------------------
  // channel drivers and result checking
  // ------------------------------------------------------------------------

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    logic signed [VAL_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_elements.size() == 0) begin
        $error("element_value unexpected: expected none, got %0d", out_if.element_value);
        failures++;
      end else begin
        want = expected_elements.pop_front();
        if (out_if.element_value !== want) begin
          $error("element_value mismatch: expected %0d, got %0d", want,
                 out_if.element_value);
          failures++;
        end
      end
    end
  end

  // offer one item, hold it until the transfer, then record its prediction
  task automatic send_item(excitation_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.bra_occupancy     <= it.bra;
    in_if.ket_occupancy     <= it.ket;
    in_if.create_first      <= it.p;
    in_if.create_second     <= it.r;
    in_if.annihilate_first  <= it.s;
    in_if.annihilate_second <= it.q;
    do @(posedge clk); while (!in_if.ready);
    expected_elements.insert(expected_elements.size(), predict_element(it));
  endtask

  task automatic send_fields(logic [OCC_W-1:0] bra, logic [OCC_W-1:0] ket,
                             logic [IDX_W-1:0] p, logic [IDX_W-1:0] r,
                             logic [IDX_W-1:0] s, logic [IDX_W-1:0] q);
    excitation_t it;
    it.bra = bra;
    it.ket = ket;
    it.p   = p;
    it.r   = r;
    it.s   = s;
    it.q   = q;
    send_item(it);
  endtask

  // stop offering, let every result out, then give the pipeline time to settle
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------

  task automatic cfg_write(int index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * index);
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (index == int'(REG_SPIN_MODE)) spin_mode_model = data[0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_spin_mode_readback();
    logic [CFG_DATA_W-1:0] data;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(REG_SPIN_MODE));
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (data[0] !== spin_mode_model) begin
      $error("spin_mode mismatch: expected %0d, got %0d", spin_mode_model, data[0]);
      failures++;
    end
  endtask

  task automatic set_spin_mode(logic mode);
    wait_drained();
    cfg_write(int'(REG_SPIN_MODE), CFG_DATA_W'(mode));
    check_spin_mode_readback();
  endtask

  // ------------------------------------------------------------------------
  // random stimulus
  // ------------------------------------------------------------------------

  // mostly real double excitations of a random ket, the rest noise
  function automatic excitation_t random_excitation(logic spin_on);
    excitation_t it;
    int          lim;
    int          sg;
    int          tu;
    int          po;
    int          ro;
    int          so;
    int          qo;
    it.bra = OCC_W'($urandom);
    it.ket = OCC_W'($urandom);
    it.p   = IDX_W'($urandom);
    it.r   = IDX_W'($urandom);
    it.s   = IDX_W'($urandom);
    it.q   = IDX_W'($urandom);
    if ($urandom_range(99) < 30) return it;
    lim  = spin_on ? ORBITALS / 2 : ORBITALS;
    it.p = IDX_W'($urandom_range(lim - 1));
    it.r = IDX_W'($urandom_range(lim - 1));
    it.s = IDX_W'($urandom_range(lim - 1));
    it.q = IDX_W'($urandom_range(lim - 1));
    sg   = spin_on ? $urandom_range(1) : 0;
    tu   = spin_on ? $urandom_range(1) : 0;
    po   = spin_on ? 2 * it.p + sg : it.p;
    ro   = spin_on ? 2 * it.r + tu : it.r;
    so   = spin_on ? 2 * it.s + tu : it.s;
    qo   = spin_on ? 2 * it.q + sg : it.q;
    it.ket[qo] = 1'b1;
    it.ket[so] = 1'b1;
    it.bra     = it.ket;
    it.bra[qo] = 1'b0;
    it.bra[so] = 1'b0;
    it.bra[po] = 1'b1;
    it.bra[ro] = 1'b1;
    // broken excitation: one stray bit in the bra
    if ($urandom_range(99) < 15) it.bra[$urandom_range(OCC_W - 1)] ^= 1'b1;
    return it;
  endfunction

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  task automatic test_reset_state();
    check_spin_mode_readback();
  endtask

  task automatic test_directed_spinless();
    set_spin_mode(1'b0);
    send_fields(16'h0000, 16'h0000, 4'd0, 4'd0, 4'd0, 4'd0);
    send_fields(16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 4'd15, 4'd15);
    send_fields(16'hFFFF, 16'hFFFF, 4'd0, 4'd1, 4'd1, 4'd0);
    send_fields(16'hFFFF, 16'hFFFF, 4'd15, 4'd14, 4'd14, 4'd15);
    send_fields(16'hFFFF, 16'hFFFF, 4'd14, 4'd15, 4'd14, 4'd15);
    // genuine excitations with both sign outcomes
    send_fields(16'h022C, 16'h000F, 4'd9, 4'd5, 4'd1, 4'd0);
    send_fields(16'h022C, 16'h000F, 4'd5, 4'd9, 4'd1, 4'd0);
    send_fields(16'h8001, 16'h8001, 4'd15, 4'd0, 4'd0, 4'd15);
    // repeated annihilation, repeated creation
    send_fields(16'h00F0, 16'h00F8, 4'd4, 4'd5, 4'd3, 4'd3);
    send_fields(16'h0088, 16'h0008, 4'd7, 4'd7, 4'd3, 4'd0);
    // stripped masks differ
    send_fields(16'h0F0F, 16'hF0F0, 4'd0, 4'd1, 4'd4, 4'd5);
  endtask

  task automatic test_directed_spin();
    set_spin_mode(1'b1);
    send_fields(16'hFFFF, 16'hFFFF, 4'd0, 4'd0, 4'd0, 4'd0);
    send_fields(16'hFFFF, 16'hFFFF, 4'd1, 4'd2, 4'd2, 4'd1);
    send_fields(16'hFFFF, 16'hFFFF, 4'd7, 4'd0, 4'd0, 4'd7);
    send_fields(16'hFFFF, 16'hFFFF, 4'd7, 4'd7, 4'd7, 4'd7);
    // spatial index beyond the orbital space
    send_fields(16'hFFFF, 16'hFFFF, 4'd15, 4'd8, 4'd8, 4'd15);
    send_fields(16'h0000, 16'h0000, 4'd3, 4'd2, 4'd1, 4'd0);
    send_fields(16'h00F0, 16'h000F, 4'd2, 4'd3, 4'd1, 4'd0);
    send_fields(16'h0C03, 16'h000F, 4'd5, 4'd0, 4'd1, 4'd0);
  endtask

  // a write to an unmapped register leaves spin_mode alone
  task automatic test_unused_register();
    set_spin_mode(1'b0);
    cfg_write(REG_UNUSED, '1);
    check_spin_mode_readback();
    send_fields(16'hFFFF, 16'hFFFF, 4'd0, 4'd1, 4'd1, 4'd0);
    set_spin_mode(1'b1);
    cfg_write(REG_UNUSED, '0);
    check_spin_mode_readback();
    send_fields(16'hFFFF, 16'hFFFF, 4'd0, 4'd1, 4'd1, 4'd0);
  endtask

  task automatic test_random_phase(int count, logic mode, int unsigned idle_pct,
                                   int unsigned stall_pct);
    set_spin_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_excitation(mode));
  endtask

  // long output hold-off while items keep coming, so the input must stall
  task automatic test_output_hold_off();
    set_spin_mode(1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_request = 60;
    repeat (40) send_item(random_excitation(1'b1));
    set_spin_mode(1'b0);
    @(posedge clk);
    hold_request = 45;
    repeat (40) send_item(random_excitation(1'b0));
  endtask

  initial begin
    rst_n                   = 1'b0;
    cfg_psel                = 1'b0;
    cfg_penable             = 1'b0;
    cfg_pwrite              = 1'b0;
    cfg_paddr               = '0;
    cfg_pwdata              = '0;
    in_if.valid             = 1'b0;
    in_if.bra_occupancy     = '0;
    in_if.ket_occupancy     = '0;
    in_if.create_first      = '0;
    in_if.create_second     = '0;
    in_if.annihilate_first  = '0;
    in_if.annihilate_second = '0;
    out_if.ready            = 1'b0;
    spin_mode_model         = 1'b0;
    send_idle_pct           = 0;
    recv_stall_pct          = 0;
    hold_request            = 0;
    hold_left               = 0;
    failures                = 0;
    cycle_count             = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_spinless();
    test_directed_spin();
    test_unused_register();
    test_random_phase(180, 1'b0, 0, 0);
    test_random_phase(180, 1'b1, 0, 0);
    test_random_phase(180, 1'b0, 56, 0);
    test_random_phase(180, 1'b1, 56, 0);
    test_random_phase(180, 1'b1, 0, 56);
    test_random_phase(180, 1'b0, 0, 56);
    test_random_phase(180, 1'b0, 13, 13);
    test_random_phase(180, 1'b1, 13, 13);
    test_output_hold_off();

    wait_drained();
    if (failures == 0) begin
      $display("PASS two_body_excitation_sign");
    end else begin
      $display("FAIL two_body_excitation_sign");
    end
    $finish;
  end

endmodule
